// ===== src/scfla_pkg.sv =====
// ============================================================================
// scfla_pkg: shared types for the size class free list allocator
// Holds the request codes and the command record passed from front to back.
// ============================================================================
package scfla_pkg;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam int ADDR_W = 18;
    localparam int CLASS_W = 4;
    localparam int CNT_W = 16;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic               is_free;
        logic               bad_class;
        logic [CLASS_W-1:0] class_sel;
        logic [ADDR_W-1:0]  block_addr;
        logic [ADDR_W-1:0]  page_addr;
        logic               page_ok;
    } scfla_cmd_t;

endpackage

// ===== src/scfla_if.sv =====
// ============================================================================
// scfla_req_if / scfla_rsp_if: request and result channels
// Valid/ready channels carrying one request or one result per transfer.
// ============================================================================
interface scfla_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [3:0]  class_sel;
    logic [17:0] block_addr;
    logic [17:0] page_addr;
    logic        page_ok;

    modport source (output valid, req_type, class_sel, block_addr, page_addr, page_ok,
                    input ready);
    modport sink (input valid, req_type, class_sel, block_addr, page_addr, page_ok,
                  output ready);
endinterface

interface scfla_rsp_if;
    logic        valid;
    logic        ready;
    logic [17:0] result_addr;
    logic        result_ok;
    logic        page_taken;
    logic [15:0] class_free;
    logic [15:0] class_total;

    modport source (output valid, result_addr, result_ok, page_taken, class_free,
                    class_total, input ready);
    modport sink (input valid, result_addr, result_ok, page_taken, class_free,
                  class_total, output ready);
endinterface

// ===== src/scfla_front.sv =====
// ============================================================================
// scfla_front: request intake and classification
// Accepts requests, checks the class range, and queues commands for the back.
// ============================================================================
module scfla_front
    import scfla_pkg::*;
#(
    parameter int NUM_CLASSES = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    scfla_req_if.sink   req,
    output scfla_cmd_t  cmd,
    output logic        cmd_valid,
    input  logic        cmd_ready
);

    // Two-entry queue between the front and the back.
    scfla_cmd_t q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    scfla_cmd_t in_cmd;
    logic       push;
    logic       pop;

    always_comb
    begin
        in_cmd.is_free    = (req.req_type == REQ_FREE);
        in_cmd.bad_class  = ({1'b0, req.class_sel} >= 5'(NUM_CLASSES));
        in_cmd.class_sel  = req.class_sel;
        in_cmd.block_addr = req.block_addr;
        in_cmd.page_addr  = req.page_addr;
        in_cmd.page_ok    = req.page_ok;
    end

    assign req.ready = (count_reg != 2'd2);
    assign push = req.valid && req.ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== src/scfla_back.sv =====
// ============================================================================
// scfla_back: free list engine
// Pops, pushes and page carving against the link memory, one command at a time.
// ============================================================================
module scfla_back
    import scfla_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int MIN_BLOCK_BYTES = 8,
    parameter int NUM_CLASSES = 10,
    parameter int ARENA_BYTES = 262144
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  scfla_cmd_t  cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    scfla_rsp_if.source rsp
);

    localparam int NUM_SLOTS = ARENA_BYTES / MIN_BLOCK_BYTES;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int MB_SH = $clog2(MIN_BLOCK_BYTES);
    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int AR_W = $clog2(ARENA_BYTES);
    localparam int PG_SLOTS = PAGE_BYTES / MIN_BLOCK_BYTES;
    localparam int CARVE_SH = PG_SH - MB_SH;
    localparam int MAX_SH = (1 << CLASS_W) - 1;
    // Wide enough that the step of the largest class and the offset past the
    // page end both fit.
    localparam int PS_W = ((CARVE_SH > MAX_SH) ? CARVE_SH : MAX_SH) + 2;
    localparam int CI_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_CARVE = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [SLOT_W-1:0] head_slot_reg [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] head_valid_reg;
    logic [CNT_W-1:0] free_cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0] total_cnt_reg [NUM_CLASSES];

    // Link memory: valid flag plus next slot.
    logic [SLOT_W:0] link_mem [NUM_SLOTS];
    logic [SLOT_W:0] link_rd_reg;

    scfla_cmd_t cur_reg;
    logic [CI_W-1:0] ci;
    logic [SLOT_W-1:0] cur_head;
    logic cur_hv;

    logic [PS_W-1:0] off_reg;        // carve offset in slots
    logic [PS_W-1:0] step_slots;
    logic [SLOT_W-1:0] page_slot;
    logic [CNT_W-1:0] pushed_reg;

    logic [AR_W-1:0] raddr_reg;
    logic ok_reg, taken_reg;
    logic [CNT_W-1:0] ofree_reg, ototal_reg;

    logic wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W:0] wr_data;
    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] carve_slot;

    assign ci = CI_W'(cur_reg.class_sel);
    assign cur_head = head_slot_reg[ci];
    assign cur_hv = head_valid_reg[ci];
    assign cmd_ready = (state_reg == ST_IDLE);
    assign step_slots = PS_W'(1) << cur_reg.class_sel;
    assign page_slot = SLOT_W'(cur_reg.page_addr[ADDR_W-1:PG_SH]) << (PG_SH - MB_SH);
    assign free_slot = SLOT_W'(cur_reg.block_addr[ADDR_W-1:MB_SH]);
    assign carve_slot = page_slot + SLOT_W'(off_reg);

    assign rsp.valid = (state_reg == ST_OUT);
    assign rsp.result_addr = ADDR_W'(raddr_reg);
    assign rsp.result_ok = ok_reg;
    assign rsp.page_taken = taken_reg;
    assign rsp.class_free = ofree_reg;
    assign rsp.class_total = ototal_reg;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = free_slot;
        wr_data = {cur_hv, cur_head};
        if (state_reg == ST_READ && !cur_reg.bad_class && cur_reg.is_free)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_CARVE && off_reg < PS_W'(PG_SLOTS))
        begin
            wr_en = 1'b1;
            wr_addr = carve_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        link_rd_reg <= link_mem[cur_head];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cur_reg.bad_class || cur_reg.is_free)
                begin
                    state_next = ST_OUT;
                end
                else if (cur_hv)
                begin
                    state_next = ST_POP;
                end
                else if (cur_reg.page_ok)
                begin
                    state_next = ST_CARVE;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_POP:
            begin
                state_next = ST_OUT;
            end
            ST_CARVE:
            begin
                if (off_reg >= PS_W'(PG_SLOTS))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_valid_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_slot_reg[i] <= '0;
                free_cnt_reg[i] <= '0;
                total_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ && !cur_reg.bad_class && cur_reg.is_free)
            begin
                head_slot_reg[ci] <= free_slot;
                head_valid_reg[ci] <= 1'b1;
                free_cnt_reg[ci] <= sat_add(free_cnt_reg[ci], CNT_W'(1));
            end
            else if (state_reg == ST_POP)
            begin
                head_valid_reg[ci] <= link_rd_reg[SLOT_W];
                head_slot_reg[ci] <= link_rd_reg[SLOT_W] ? link_rd_reg[SLOT_W-1:0] : '0;
                if (free_cnt_reg[ci] != '0)
                begin
                    free_cnt_reg[ci] <= free_cnt_reg[ci] - CNT_W'(1);
                end
            end
            else if (state_reg == ST_CARVE)
            begin
                if (off_reg < PS_W'(PG_SLOTS))
                begin
                    head_slot_reg[ci] <= carve_slot;
                    head_valid_reg[ci] <= 1'b1;
                end
                else
                begin
                    free_cnt_reg[ci] <= sat_add(free_cnt_reg[ci], pushed_reg);
                    total_cnt_reg[ci] <= sat_add(total_cnt_reg[ci], pushed_reg + CNT_W'(1));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            cur_reg <= cmd;
        end
        if (state_reg == ST_READ)
        begin
            off_reg <= step_slots;
            pushed_reg <= '0;
            ok_reg <= !cur_reg.bad_class && (cur_reg.is_free || cur_hv || cur_reg.page_ok);
            taken_reg <= !cur_reg.bad_class && !cur_reg.is_free && !cur_hv && cur_reg.page_ok;
            if (!cur_reg.bad_class && !cur_reg.is_free && !cur_hv && cur_reg.page_ok)
            begin
                raddr_reg <= AR_W'(page_slot) << MB_SH;
            end
            else if (!cur_reg.bad_class && !cur_reg.is_free && cur_hv)
            begin
                raddr_reg <= AR_W'(cur_head) << MB_SH;
            end
            else
            begin
                raddr_reg <= '0;
            end
        end
        else if (state_reg == ST_CARVE && off_reg < PS_W'(PG_SLOTS))
        begin
            off_reg <= off_reg + step_slots;
            pushed_reg <= pushed_reg + CNT_W'(1);
        end
        if (state_reg != ST_OUT && state_next == ST_OUT)
        begin
            if (cur_reg.bad_class)
            begin
                ofree_reg <= '0;
                ototal_reg <= '0;
            end
            else if (state_reg == ST_READ && cur_reg.is_free)
            begin
                ofree_reg <= sat_add(free_cnt_reg[ci], CNT_W'(1));
                ototal_reg <= total_cnt_reg[ci];
            end
            else if (state_reg == ST_POP && free_cnt_reg[ci] != '0)
            begin
                ofree_reg <= free_cnt_reg[ci] - CNT_W'(1);
                ototal_reg <= total_cnt_reg[ci];
            end
            else if (state_reg == ST_CARVE)
            begin
                ofree_reg <= sat_add(free_cnt_reg[ci], pushed_reg);
                ototal_reg <= sat_add(total_cnt_reg[ci], pushed_reg + CNT_W'(1));
            end
            else
            begin
                ofree_reg <= free_cnt_reg[ci];
                ototal_reg <= total_cnt_reg[ci];
            end
        end
    end

endmodule

// ===== src/size_class_free_list_allocator.sv =====
// ============================================================================
// size_class_free_list_allocator: segregated free list block allocator
// Per-class LIFO free lists of blocks carved from pages of a page source.
// ============================================================================
// Usage: requests arrive on the req channel (allocate or free, with a size
// class and, for allocate, the page currently offered by the page source).
// Every request produces exactly one result transfer on the rsp channel.
// A front end classifies requests into a two-entry queue; the back end owns
// the list heads, counters and the link memory and executes one command at
// a time. An allocate that carves a page writes the link memory once for each
// block that it pushes onto the class list. The back end takes no new command
// until the result of the current one has been transferred. Requests keep
// arriving into the queue while the back end works or while a result waits.
// Reset empties all lists and clears both counters of every class; the link
// memory is not cleared, since a link is only read after it was written.
// When the receiver stalls, the result holds and the back end waits; the
// front end keeps taking requests until its queue is full.
// ============================================================================
module size_class_free_list_allocator
    import scfla_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int MIN_BLOCK_BYTES = 8,
    parameter int NUM_CLASSES = 10,
    parameter int ARENA_BYTES = 262144
)
(
    input  logic       clk,
    input  logic       rst_n,
    scfla_req_if.sink  req,
    scfla_rsp_if.source rsp
);

    scfla_cmd_t cmd;
    logic       cmd_valid;
    logic       cmd_ready;

    // Front end: accepts and classifies each request transfer.
    scfla_front #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .cmd(cmd),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready)
    );

    // Back end: list operations and result delivery.
    scfla_back #(
        .PAGE_BYTES(PAGE_BYTES),
        .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES),
        .NUM_CLASSES(NUM_CLASSES),
        .ARENA_BYTES(ARENA_BYTES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .rsp(rsp)
    );

endmodule
